// File: hdl/rsag_pkg.sv
// ----------------------------------------------------------------------------
// rsag_pkg
// Shared widths, configuration record and rounding helper for the rotation
// source address generator.
// ----------------------------------------------------------------------------
package rsag_pkg;

  // Sizing limits
  localparam int MAX_DIM  = 4096;
  localparam int MAX_COMP = 4;

  // Field widths
  localparam int COORD_W    = $clog2(MAX_DIM);        // window origin
  localparam int DIM_W      = COORD_W + 1;            // sizes, input coordinates
  localparam int COMP_W     = $clog2(MAX_COMP) + 1;   // bytes per pixel
  localparam int FACT_W     = 16;                     // Q2.14 factor
  localparam int Q_SHIFT    = FACT_W - 2;             // fraction bits of factor
  localparam int SRC_W      = 15;                     // source coordinate
  localparam int SOFF_W     = 29;                     // source byte offset
  localparam int DOFF_W     = 26;                     // destination byte offset
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Internal widths
  localparam int C2_W      = DIM_W + 1;               // centre in half pixels
  localparam int D2_W      = DIM_W + 3;               // difference in half pixels
  localparam int DIFF_W    = DIM_W + 1;               // coordinate minus origin
  localparam int PROD_W    = D2_W + FACT_W;           // rotation product
  localparam int SUM_W     = PROD_W + 1;              // rotated fixed point sum
  localparam int FRAC_BITS = Q_SHIFT + 1;             // half pixel times Q2.14
  localparam int TRNC_W    = SUM_W - FRAC_BITS + 1;   // truncated signed value
  localparam int ROW_W     = DIFF_W + DIM_W + 1;      // destination row product
  localparam int SROW_W    = SRC_W + DIM_W + 1;       // source row product
  localparam int LIN_W     = SROW_W + 1;              // source pixel index
  localparam int SPRD_W    = LIN_W + COMP_W + 1;      // source byte offset, raw

  localparam int SRC_MAX  = 2 ** (SRC_W - 1) - 1;
  localparam int SRC_MIN  = -(2 ** (SRC_W - 1));
  localparam int SOFF_MAX = 2 ** (SOFF_W - 1) - 1;
  localparam int SOFF_MIN = -(2 ** (SOFF_W - 1));
  localparam int HALF_FX  = 2 ** (FRAC_BITS - 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_LEFT   = 3'd0,
    REG_DEST_TOP    = 3'd1,
    REG_DEST_WIDTH  = 3'd2,
    REG_DEST_LENGTH = 3'd3,
    REG_SRC_WIDTH   = 3'd4,
    REG_COMPONENTS  = 3'd5,
    REG_COS         = 3'd6,
    REG_SIN         = 3'd7
  } cfg_reg_t;

  // Configuration register file
  typedef struct packed {
    logic [COORD_W-1:0]       dest_left;
    logic [COORD_W-1:0]       dest_top;
    logic [DIM_W-1:0]         dest_width;
    logic [DIM_W-1:0]         dest_length;
    logic [DIM_W-1:0]         src_width;
    logic [COMP_W-1:0]        components;
    logic signed [FACT_W-1:0] cos_q14;
    logic signed [FACT_W-1:0] sin_q14;
  } cfg_t;

  // Drop the fraction toward zero, then saturate to the coordinate range
  function automatic logic signed [SRC_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0]              mag;
    logic [SUM_W-FRAC_BITS-1:0]    q;
    logic signed [TRNC_W-1:0]      t;
    logic signed [SRC_W-1:0]       r;
    mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    q   = mag[SUM_W-1:FRAC_BITS];
    t   = s[SUM_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (t > $signed(TRNC_W'(SRC_MAX))) begin
      r = SRC_W'(SRC_MAX);
    end else if (t < $signed(TRNC_W'(SRC_MIN))) begin
      r = SRC_W'(SRC_MIN);
    end else begin
      r = SRC_W'(t);
    end
    return r;
  endfunction

endpackage

// File: hdl/rsag_rotate.sv
// ----------------------------------------------------------------------------
// rsag_rotate
// Four-stage pipeline: centre differences, rotation products, fixed point
// sums, then rounding to source coordinates and the destination byte offset.
// ----------------------------------------------------------------------------
module rsag_rotate (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rsag_pkg::cfg_t                       cfg,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  logic [rsag_pkg::DIM_W-1:0]           dest_h,
  input  logic [rsag_pkg::DIM_W-1:0]           dest_v,
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output logic signed [rsag_pkg::SRC_W-1:0]    src_h,
  output logic signed [rsag_pkg::SRC_W-1:0]    src_v,
  output logic [rsag_pkg::DOFF_W-1:0]          dest_offset
);
  import rsag_pkg::*;

  localparam int NSTG = 4;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] adv;

  // Stage 1: centre and differences
  logic [C2_W-1:0]          ch2_nxt, cv2_nxt, s1_ch2_r, s1_cv2_r;
  logic signed [D2_W-1:0]   dh2_nxt, dv2_nxt, s1_dh2_r, s1_dv2_r;
  logic signed [DIFF_W-1:0] dhd_nxt, dvd_nxt, s1_dhd_r, s1_dvd_r;
  // Stage 2: products
  logic signed [PROD_W-1:0] p_hc_nxt, p_vs_nxt, p_hs_nxt, p_vc_nxt;
  logic signed [PROD_W-1:0] s2_p_hc_r, s2_p_vs_r, s2_p_hs_r, s2_p_vc_r;
  logic signed [ROW_W-1:0]  row_nxt, s2_row_r;
  logic [C2_W-1:0]          s2_ch2_r, s2_cv2_r;
  logic signed [DIFF_W-1:0] s2_dhd_r;
  // Stage 3: sums
  logic signed [SUM_W-1:0]  shfx_nxt, svfx_nxt, s3_shfx_r, s3_svfx_r;
  logic signed [ROW_W-1:0]  drow_nxt, s3_drow_r;
  // Stage 4: results
  logic signed [SRC_W-1:0]  sh_nxt, sv_nxt, s4_sh_r, s4_sv_r;
  logic [DOFF_W-1:0]        doff_nxt, s4_doff_r;

  // Advance a stage when it is empty or the one below moves on
  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || dn_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign up_ready = adv[0];
  assign dn_valid = v_r[NSTG-1];

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= up_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage logic
  always_comb begin
    ch2_nxt = {1'b0, cfg.dest_left, 1'b0} + C2_W'(cfg.dest_width);
    cv2_nxt = {1'b0, cfg.dest_top, 1'b0} + C2_W'(cfg.dest_length);
    dh2_nxt = $signed(D2_W'({dest_h, 1'b0})) - $signed(D2_W'(ch2_nxt));
    dv2_nxt = $signed(D2_W'({dest_v, 1'b0})) - $signed(D2_W'(cv2_nxt));
    dhd_nxt = $signed(DIFF_W'(dest_h)) - $signed(DIFF_W'(cfg.dest_left));
    dvd_nxt = $signed(DIFF_W'(dest_v)) - $signed(DIFF_W'(cfg.dest_top));

    p_hc_nxt = s1_dh2_r * cfg.cos_q14;
    p_vs_nxt = s1_dv2_r * cfg.sin_q14;
    p_hs_nxt = s1_dh2_r * cfg.sin_q14;
    p_vc_nxt = s1_dv2_r * cfg.cos_q14;
    row_nxt  = s1_dvd_r * $signed({1'b0, cfg.dest_width});

    shfx_nxt = SUM_W'(s2_p_hc_r) - SUM_W'(s2_p_vs_r)
             + $signed(SUM_W'({s2_ch2_r, {Q_SHIFT{1'b0}}})) + $signed(SUM_W'(HALF_FX));
    svfx_nxt = SUM_W'(s2_p_hs_r) + SUM_W'(s2_p_vc_r)
             + $signed(SUM_W'({s2_cv2_r, {Q_SHIFT{1'b0}}})) + $signed(SUM_W'(HALF_FX));
    drow_nxt = s2_row_r + ROW_W'(s2_dhd_r);

    sh_nxt   = round_sat(s3_shfx_r);
    sv_nxt   = round_sat(s3_svfx_r);
    doff_nxt = DOFF_W'(s3_drow_r * $signed({1'b0, cfg.components}));
  end

  // Payload registers, held while stalled
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_ch2_r <= ch2_nxt;
      s1_cv2_r <= cv2_nxt;
      s1_dh2_r <= dh2_nxt;
      s1_dv2_r <= dv2_nxt;
      s1_dhd_r <= dhd_nxt;
      s1_dvd_r <= dvd_nxt;
    end
    if (adv[1]) begin
      s2_p_hc_r <= p_hc_nxt;
      s2_p_vs_r <= p_vs_nxt;
      s2_p_hs_r <= p_hs_nxt;
      s2_p_vc_r <= p_vc_nxt;
      s2_row_r  <= row_nxt;
      s2_ch2_r  <= s1_ch2_r;
      s2_cv2_r  <= s1_cv2_r;
      s2_dhd_r  <= s1_dhd_r;
    end
    if (adv[2]) begin
      s3_shfx_r <= shfx_nxt;
      s3_svfx_r <= svfx_nxt;
      s3_drow_r <= drow_nxt;
    end
    if (adv[3]) begin
      s4_sh_r   <= sh_nxt;
      s4_sv_r   <= sv_nxt;
      s4_doff_r <= doff_nxt;
    end
  end

  assign src_h       = s4_sh_r;
  assign src_v       = s4_sv_r;
  assign dest_offset = s4_doff_r;

  // A stalled last stage keeps its beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NSTG-1] && !dn_ready) |=> v_r[NSTG-1])
    else $error("rsag_rotate: stalled beat dropped");

  // A full pipeline with a stalled sink refuses new beats
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    ((&v_r) && !dn_ready) |-> !up_ready)
    else $error("rsag_rotate: beat taken while full");

endmodule

// File: hdl/rsag_offset.sv
// ----------------------------------------------------------------------------
// rsag_offset
// Four-stage pipeline for the source byte offset: row product, pixel index,
// scale by bytes per pixel, saturate. Holds the output registers.
// ----------------------------------------------------------------------------
module rsag_offset (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rsag_pkg::cfg_t                       cfg,
  input  logic                                 up_valid,
  output logic                                 up_ready,
  input  logic signed [rsag_pkg::SRC_W-1:0]    src_h_in,
  input  logic signed [rsag_pkg::SRC_W-1:0]    src_v_in,
  input  logic [rsag_pkg::DOFF_W-1:0]          dest_offset_in,
  output logic                                 dn_valid,
  input  logic                                 dn_ready,
  output logic signed [rsag_pkg::SRC_W-1:0]    src_h,
  output logic signed [rsag_pkg::SRC_W-1:0]    src_v,
  output logic signed [rsag_pkg::SOFF_W-1:0]   src_offset,
  output logic [rsag_pkg::DOFF_W-1:0]          dest_offset
);
  import rsag_pkg::*;

  localparam int NSTG = 4;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] adv;

  logic signed [SRC_W-1:0]  s5_sh_r, s5_sv_r, s6_sh_r, s6_sv_r, s7_sh_r, s7_sv_r;
  logic signed [SRC_W-1:0]  s8_sh_r, s8_sv_r;
  logic [DOFF_W-1:0]        s5_doff_r, s6_doff_r, s7_doff_r, s8_doff_r;
  logic signed [SROW_W-1:0] row_nxt, s5_row_r;
  logic signed [LIN_W-1:0]  lin_nxt, s6_lin_r;
  logic signed [SPRD_W-1:0] prod_nxt, s7_prod_r;
  logic signed [SOFF_W-1:0] soff_nxt, s8_soff_r;

  // Advance a stage when it is empty or the one below moves on
  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || dn_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign up_ready = adv[0];
  assign dn_valid = v_r[NSTG-1];

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= up_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage logic
  always_comb begin
    row_nxt  = src_v_in * $signed({1'b0, cfg.src_width});
    lin_nxt  = LIN_W'(s5_row_r) + LIN_W'(s5_sh_r);
    prod_nxt = s6_lin_r * $signed({1'b0, cfg.components});
    // Saturate to the offset range
    if (s7_prod_r > $signed(SPRD_W'(SOFF_MAX))) begin
      soff_nxt = SOFF_W'(SOFF_MAX);
    end else if (s7_prod_r < $signed(SPRD_W'(SOFF_MIN))) begin
      soff_nxt = SOFF_W'(SOFF_MIN);
    end else begin
      soff_nxt = SOFF_W'(s7_prod_r);
    end
  end

  // Payload registers, held while stalled
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s5_row_r  <= row_nxt;
      s5_sh_r   <= src_h_in;
      s5_sv_r   <= src_v_in;
      s5_doff_r <= dest_offset_in;
    end
    if (adv[1]) begin
      s6_lin_r  <= lin_nxt;
      s6_sh_r   <= s5_sh_r;
      s6_sv_r   <= s5_sv_r;
      s6_doff_r <= s5_doff_r;
    end
    if (adv[2]) begin
      s7_prod_r <= prod_nxt;
      s7_sh_r   <= s6_sh_r;
      s7_sv_r   <= s6_sv_r;
      s7_doff_r <= s6_doff_r;
    end
    if (adv[3]) begin
      s8_soff_r <= soff_nxt;
      s8_sh_r   <= s7_sh_r;
      s8_sv_r   <= s7_sv_r;
      s8_doff_r <= s7_doff_r;
    end
  end

  assign src_h       = s8_sh_r;
  assign src_v       = s8_sv_r;
  assign src_offset  = s8_soff_r;
  assign dest_offset = s8_doff_r;

  // A stalled output stage keeps its beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NSTG-1] && !dn_ready) |=> v_r[NSTG-1])
    else $error("rsag_offset: stalled beat dropped");

  // A full pipeline with a stalled sink refuses new beats
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    ((&v_r) && !dn_ready) |-> !up_ready)
    else $error("rsag_offset: beat taken while full");

endmodule

// File: hdl/rotation_source_address_generator.sv
// Throughput: one beat per cycle unless out_stall holds the pipeline; four rotation
//   stages then four offset stages, no multiplier wider than 16x16 bits apart from
//   the narrow bytes per pixel scales.
// Reset: synchronous, rst_n low clears all valid bits and loads the register
//   reset values; the block accepts beats in the first cycle after reset.
// ----------------------------------------------------------------------------
// rotation_source_address_generator
// Rotates destination pixel coordinates about the window centre and returns
// the rounded, saturated source pixel with its source and destination byte offsets.
// ----------------------------------------------------------------------------
module rotation_source_address_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rsag_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rsag_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [rsag_pkg::DIM_W-1:0]           in_dest_h,
  input  logic [rsag_pkg::DIM_W-1:0]           in_dest_v,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [rsag_pkg::SRC_W-1:0]    out_src_h,
  output logic signed [rsag_pkg::SRC_W-1:0]    out_src_v,
  output logic signed [rsag_pkg::SOFF_W-1:0]   out_src_offset,
  output logic [rsag_pkg::DOFF_W-1:0]          out_dest_offset
);
  import rsag_pkg::*;

  cfg_t cfg_r;

  logic                     rot_ready, rot_valid, off_ready;
  logic signed [SRC_W-1:0]  rot_sh, rot_sv;
  logic [DOFF_W-1:0]        rot_doff;

  assign cfg_ready = 1'b1;

  // Register file: load a beat into the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_left   <= '0;
      cfg_r.dest_top    <= '0;
      cfg_r.dest_width  <= DIM_W'(1);
      cfg_r.dest_length <= DIM_W'(1);
      cfg_r.src_width   <= DIM_W'(1);
      cfg_r.components  <= COMP_W'(1);
      cfg_r.cos_q14     <= FACT_W'(2 ** Q_SHIFT);
      cfg_r.sin_q14     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEST_LEFT:   cfg_r.dest_left   <= cfg_data[COORD_W-1:0];
        REG_DEST_TOP:    cfg_r.dest_top    <= cfg_data[COORD_W-1:0];
        REG_DEST_WIDTH:  cfg_r.dest_width  <= cfg_data[DIM_W-1:0];
        REG_DEST_LENGTH: cfg_r.dest_length <= cfg_data[DIM_W-1:0];
        REG_SRC_WIDTH:   cfg_r.src_width   <= cfg_data[DIM_W-1:0];
        REG_COMPONENTS:  cfg_r.components  <= cfg_data[COMP_W-1:0];
        REG_COS:         cfg_r.cos_q14     <= $signed(cfg_data[FACT_W-1:0]);
        REG_SIN:         cfg_r.sin_q14     <= $signed(cfg_data[FACT_W-1:0]);
        default: ;
      endcase
    end
  end

  // Coordinate rotation
  rsag_rotate u_rotate (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .up_valid    (in_valid),
    .up_ready    (rot_ready),
    .dest_h      (in_dest_h),
    .dest_v      (in_dest_v),
    .dn_valid    (rot_valid),
    .dn_ready    (off_ready),
    .src_h       (rot_sh),
    .src_v       (rot_sv),
    .dest_offset (rot_doff)
  );

  // Source offset and output registers
  rsag_offset u_offset (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .up_valid       (rot_valid),
    .up_ready       (off_ready),
    .src_h_in       (rot_sh),
    .src_v_in       (rot_sv),
    .dest_offset_in (rot_doff),
    .dn_valid       (out_valid),
    .dn_ready       (!out_stall),
    .src_h          (out_src_h),
    .src_v          (out_src_v),
    .src_offset     (out_src_offset),
    .dest_offset    (out_dest_offset)
  );

  assign in_stall = !rot_ready;

  // Input backs up only behind a stalled, occupied output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("rsag: input stalled with output free");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("rsag: result beat right after reset");

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Rotation source address generator testbench
// Streams destination pixels through the block over a series of register
// settings. Each pixel's source coordinates and byte offsets are predicted
// on the input handshake and compared field by field with the result beats.
// Both channels stall and idle at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rsag_pkg::*;

  typedef struct {
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] v;
  } pixel_t;

  typedef struct {
    logic signed [SRC_W-1:0]  src_h;
    logic signed [SRC_W-1:0]  src_v;
    logic signed [SOFF_W-1:0] src_offset;
    logic [DOFF_W-1:0]        dest_offset;
  } source_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int IDLE_PERCENT   = 11;
  localparam int RANDOM_PHASES  = 9;
  localparam int PIXELS_PER_SET = 78;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [DIM_W-1:0]             in_dest_h = '0;
  logic [DIM_W-1:0]             in_dest_v = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [SRC_W-1:0]      out_src_h;
  logic signed [SRC_W-1:0]      out_src_v;
  logic signed [SOFF_W-1:0]     out_src_offset;
  logic [DOFF_W-1:0]            out_dest_offset;

  cfg_t    regs;
  pixel_t  pending_pixels[$];
  source_t expected_sources[$];
  int      mismatch_count = 0;
  int      stuck_cycles = 0;
  bit      calm = 1'b0;

  rotation_source_address_generator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_dest_h       (in_dest_h),
    .in_dest_v       (in_dest_v),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_src_h       (out_src_h),
    .out_src_v       (out_src_v),
    .out_src_offset  (out_src_offset),
    .out_dest_offset (out_dest_offset)
  );

  always #5 clk = ~clk;

  // Prediction
  function automatic longint clip(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // Drop the fraction bits of the magnitude, so the value truncates toward zero
  function automatic longint drop_fraction(input longint s);
    return (s >= 0) ? (s >>> FRAC_BITS) : -((-s) >>> FRAC_BITS);
  endfunction

  function automatic source_t rotate_to_source(input pixel_t p);
    longint  cs, sn, comp, ch2, cv2, dh2, dv2, sh, sv, soff, doff;
    source_t r;
    cs   = longint'($signed(regs.cos_q14));
    sn   = longint'($signed(regs.sin_q14));
    comp = longint'(regs.components);
    // centre and differences in half pixels
    ch2  = 2 * longint'(regs.dest_left) + longint'(regs.dest_width);
    cv2  = 2 * longint'(regs.dest_top) + longint'(regs.dest_length);
    dh2  = 2 * longint'(p.h) - ch2;
    dv2  = 2 * longint'(p.v) - cv2;
    sh   = clip(drop_fraction(dh2 * cs - dv2 * sn + (ch2 << Q_SHIFT) + HALF_FX),
                SRC_MIN, SRC_MAX);
    sv   = clip(drop_fraction(dh2 * sn + dv2 * cs + (cv2 << Q_SHIFT) + HALF_FX),
                SRC_MIN, SRC_MAX);
    soff = clip(sv * longint'(regs.src_width) * comp + sh * comp, SOFF_MIN, SOFF_MAX);
    doff = (longint'(p.v) - longint'(regs.dest_top)) * longint'(regs.dest_width) * comp
         + (longint'(p.h) - longint'(regs.dest_left)) * comp;
    r.src_h       = SRC_W'(sh);
    r.src_v       = SRC_W'(sv);
    r.src_offset  = SOFF_W'(soff);
    r.dest_offset = DOFF_W'(doff);
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Input driver: predict on each accepted beat, hold while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_sources.push_back(rotate_to_source(pending_pixels.pop_front()));
      end
      if (!(in_valid && in_stall)) begin
        if (pending_pixels.size() != 0 &&
            (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          in_valid  <= 1'b1;
          in_dest_h <= pending_pixels[0].h;
          in_dest_v <= pending_pixels[0].v;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted beat with the oldest prediction
  always @(posedge clk) begin
    source_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_sources.size() == 0) begin
          flag_mismatch("result beat with no pixel outstanding");
        end else begin
          want = expected_sources.pop_front();
          if (out_src_h !== want.src_h)
            flag_mismatch($sformatf("src_h %0d, expected %0d", out_src_h, want.src_h));
          if (out_src_v !== want.src_v)
            flag_mismatch($sformatf("src_v %0d, expected %0d", out_src_v, want.src_v));
          if (out_src_offset !== want.src_offset)
            flag_mismatch($sformatf("src_offset %0d, expected %0d",
                                    out_src_offset, want.src_offset));
          if (out_dest_offset !== want.dest_offset)
            flag_mismatch($sformatf("dest_offset %0d, expected %0d",
                                    out_dest_offset, want.dest_offset));
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  // Watchdog: give up when no channel moves a beat for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEST_LEFT:   regs.dest_left   = value[COORD_W-1:0];
      REG_DEST_TOP:    regs.dest_top    = value[COORD_W-1:0];
      REG_DEST_WIDTH:  regs.dest_width  = value[DIM_W-1:0];
      REG_DEST_LENGTH: regs.dest_length = value[DIM_W-1:0];
      REG_SRC_WIDTH:   regs.src_width   = value[DIM_W-1:0];
      REG_COMPONENTS:  regs.components  = value[COMP_W-1:0];
      REG_COS:         regs.cos_q14     = value;
      REG_SIN:         regs.sin_q14     = value;
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [COORD_W-1:0] left, input logic [COORD_W-1:0] top,
                              input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] length,
                              input logic [DIM_W-1:0] srcw, input logic [COMP_W-1:0] comp,
                              input logic [FACT_W-1:0] cs, input logic [FACT_W-1:0] sn);
    write_reg(REG_DEST_LEFT, CFG_DATA_W'(left));
    write_reg(REG_DEST_TOP, CFG_DATA_W'(top));
    write_reg(REG_DEST_WIDTH, CFG_DATA_W'(width));
    write_reg(REG_DEST_LENGTH, CFG_DATA_W'(length));
    write_reg(REG_SRC_WIDTH, CFG_DATA_W'(srcw));
    write_reg(REG_COMPONENTS, CFG_DATA_W'(comp));
    write_reg(REG_COS, cs);
    write_reg(REG_SIN, sn);
    @(negedge clk);
  endtask

  // Mostly sane windows and angles, sometimes any register value at all
  task automatic random_setting();
    if ($urandom_range(0, 3) == 0) begin
      load_setting(COORD_W'($urandom), COORD_W'($urandom), DIM_W'($urandom),
                   DIM_W'($urandom), DIM_W'($urandom), COMP_W'($urandom),
                   FACT_W'($urandom), FACT_W'($urandom));
    end else begin
      load_setting(COORD_W'($urandom_range(0, 4095)), COORD_W'($urandom_range(0, 4095)),
                   DIM_W'($urandom_range(1, 4096)), DIM_W'($urandom_range(1, 4096)),
                   DIM_W'($urandom_range(1, 4096)), COMP_W'($urandom_range(1, 4)),
                   FACT_W'(int'($urandom_range(0, 32768)) - 16384),
                   FACT_W'(int'($urandom_range(0, 32768)) - 16384));
    end
  endtask

  task automatic queue_pixel(input int h, input int v);
    pixel_t p;
    p.h = DIM_W'(h);
    p.v = DIM_W'(v);
    pending_pixels.push_back(p);
  endtask

  // Mostly pixels inside the window, the rest anywhere in the field range
  task automatic queue_random_pixel();
    int h, v;
    if ($urandom_range(0, 4) == 0) begin
      h = $urandom_range(0, 8191);
      v = $urandom_range(0, 8191);
    end else begin
      h = regs.dest_left + ((regs.dest_width == 0) ? 0 : $urandom_range(0, regs.dest_width - 1));
      v = regs.dest_top + ((regs.dest_length == 0) ? 0 : $urandom_range(0, regs.dest_length - 1));
    end
    queue_pixel(h, v);
  endtask

  task automatic await_drain();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || expected_sources.size() != 0 || in_valid);
  endtask

  // Stimulus
  initial begin
    regs = '{dest_left: '0, dest_top: '0, dest_width: DIM_W'(1), dest_length: DIM_W'(1),
             src_width: DIM_W'(1), components: COMP_W'(1), cos_q14: FACT_W'(16384),
             sin_q14: '0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: identity about a one-pixel window, field extremes
    queue_pixel(0, 0);
    queue_pixel(8191, 8191);
    queue_pixel(0, 8191);
    queue_pixel(8191, 0);
    queue_pixel(5461, 2730);
    queue_pixel(2730, 5461);
    await_drain();

    // factors of -2.0 and nearly 2.0, largest sizes: coordinate and offset
    // saturation, pixels left of and above the window
    load_setting(12'd4095, 12'd4095, 13'd8191, 13'd8191, 13'd8191, 3'd7,
                 16'h8000, 16'h7fff);
    queue_pixel(0, 0);
    queue_pixel(8191, 8191);
    queue_pixel(4095, 4095);
    queue_pixel(0, 8191);
    queue_pixel(8191, 0);
    await_drain();

    // zero sizes, zero components and zero factors
    load_setting(12'd0, 12'd0, 13'd0, 13'd0, 13'd0, 3'd0, 16'h0000, 16'h0000);
    queue_pixel(0, 0);
    queue_pixel(8191, 8191);
    queue_pixel(3, 7);
    await_drain();

    // half turn in a small window: sources fall off the image
    load_setting(12'd0, 12'd0, 13'd8, 13'd8, 13'd8, 3'd4, 16'hc000, 16'h0000);
    queue_pixel(7, 7);
    queue_pixel(0, 0);
    queue_pixel(8191, 8191);
    await_drain();

    // quarter turn about a half-pixel centre: sources land on whole pixels
    load_setting(12'd100, 12'd200, 13'd5, 13'd7, 13'd640, 3'd3, 16'h0000, 16'h4000);
    queue_pixel(100, 200);
    queue_pixel(104, 206);
    queue_pixel(102, 203);
    await_drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm = (ph == RANDOM_PHASES / 2);
      random_setting();
      for (int n = 0; n < PIXELS_PER_SET; n++) queue_random_pixel();
      await_drain();
    end
    calm = 1'b0;

    // catch stray result beats before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
